### rtl/key_press_dimmer_control_unit_defines.svh
// ----------------------------------------------------------------------------
// key press dimmer control: assertion macros
// shared assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef KEY_PRESS_DIMMER_CONTROL_UNIT_DEFINES_SVH
`define KEY_PRESS_DIMMER_CONTROL_UNIT_DEFINES_SVH

// check under reset gating
`define KPD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also holds while reset is high
`define KPD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/kpd_pkg.sv
// ----------------------------------------------------------------------------
// key press dimmer control package
// register indexes, codes and constants of the dimmer controller
// ----------------------------------------------------------------------------
package kpd_pkg;

  localparam int unsigned DUTY_W   = 16;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned OUT_W    = 40;

  localparam logic [COUNT_W-1:0] HOLD_MAX = 8'd250;

  localparam logic [DUTY_W-1:0]  DUTY_STEP_RST      = 16'd10;
  localparam logic [DUTY_W-1:0]  DUTY_TOTAL_RST     = 16'd100;
  localparam logic [COUNT_W-1:0] PRESCALE_LIMIT_RST = 8'd5;
  localparam logic [COUNT_W-1:0] LONG_THRESHOLD_RST = 8'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DUTY_STEP      = 2'd0,
    REG_DUTY_TOTAL     = 2'd1,
    REG_PRESCALE_LIMIT = 2'd2,
    REG_LONG_THRESHOLD = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_A    = 2'd1,
    MODE_B    = 2'd2,
    MODE_BOTH = 2'd3
  } light_mode_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_LONG  = 2'd1,
    EV_SHORT = 2'd2
  } press_event_t;

endpackage

### rtl/key_press_dimmer_control_unit.sv
// ----------------------------------------------------------------------------
// key press dimmer control unit
// short and long key press detection driving a two channel dimmer
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one timer tick per item, tdata bit 0 is the key level.
//   m_axis returns one item per tick: both duties, the light mode and the
//   press event fired on that tick.
//   cfg writes one of four registers by index; cfg_ready is always high and
//   writes are meant only while no tick is in flight.
// timing:
//   the result of an accepted tick is registered straight into the output
//   register; one tick per cycle unless m_axis stalls, set by the single pass
//   of next-state logic between the state registers and the output register.
// reset:
//   rst clears all key state, the mode and both duties, loads the register
//   defaults and empties the output register.
// stall:
//   the output register holds its item while m_axis_tready is low; a new
//   tick is taken in the same cycle the held item leaves.
// ----------------------------------------------------------------------------
module key_press_dimmer_control_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,   // key_down
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // duty_a, duty_b, light_mode, press_event
  output logic [kpd_pkg::OUT_W-1:0]           m_axis_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [kpd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [kpd_pkg::DUTY_W-1:0]          cfg_data
);
  import kpd_pkg::*;

  logic [DUTY_W-1:0]  duty_step;
  logic [DUTY_W-1:0]  duty_total;
  logic [COUNT_W-1:0] prescale_limit;
  logic [COUNT_W-1:0] long_threshold;

  logic [COUNT_W-1:0] prescale_count, prescale_count_next;
  logic [COUNT_W-1:0] hold_count, hold_count_next;
  logic               held_last, held_last_next;
  logic               long_seen, long_seen_next;
  logic               short_pending, short_pending_next;
  light_mode_t        mode_reg, mode_reg_next;
  logic [DUTY_W-1:0]  duty_a_reg, duty_a_reg_next;
  logic [DUTY_W-1:0]  duty_b_reg, duty_b_reg_next;
  press_event_t       press_event;

  logic               in_accept;
  logic               key_down;
  logic               prescale_wrap;
  logic [COUNT_W-1:0] hold_count_tick;
  logic [DUTY_W-1:0]  step_in;
  logic [DUTY_W:0]    step_sum;
  logic [DUTY_W-1:0]  step_out;
  light_mode_t        mode_inc;
  logic [DUTY_W-1:0]  seed_a;
  logic [DUTY_W-1:0]  seed_b;
  logic [DUTY_W-1:0]  seed_max;

  logic [DUTY_W-1:0]  out_duty_a;
  logic [DUTY_W-1:0]  out_duty_b;
  light_mode_t        out_mode;
  press_event_t       out_event;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign key_down      = s_axis_tdata[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_step      <= DUTY_STEP_RST;
      duty_total     <= DUTY_TOTAL_RST;
      prescale_limit <= PRESCALE_LIMIT_RST;
      long_threshold <= LONG_THRESHOLD_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DUTY_STEP:      duty_step      <= cfg_data;
        REG_DUTY_TOTAL:     duty_total     <= cfg_data;
        REG_PRESCALE_LIMIT: prescale_limit <= cfg_data[COUNT_W-1:0];
        REG_LONG_THRESHOLD: long_threshold <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // prescaler and hold counter
  always_comb begin
    prescale_wrap   = prescale_count >= prescale_limit;
    hold_count_tick = hold_count;
    if (prescale_wrap && held_last && !long_seen && hold_count < HOLD_MAX) begin
      hold_count_tick = hold_count + COUNT_W'(1);
    end
    prescale_count_next = (prescale_wrap ? '0 : prescale_count) + COUNT_W'(1);
  end

  // shared step adder, full width sum before the compare
  always_comb begin
    step_in  = (mode_reg == MODE_B) ? duty_b_reg : duty_a_reg;
    step_sum = {1'b0, step_in} + {1'b0, duty_step};
    step_out = (step_sum > {1'b0, duty_total}) ? duty_step : step_sum[DUTY_W-1:0];
  end

  // short press seeds
  always_comb begin
    mode_inc = light_mode_t'(mode_reg + 2'd1);
    seed_a   = (duty_a_reg == '0) ? duty_step : duty_a_reg;
    seed_b   = (duty_b_reg == '0) ? duty_step : duty_b_reg;
    seed_max = (seed_a < seed_b) ? seed_b : seed_a;
  end

  always_comb begin
    hold_count_next    = hold_count_tick;
    held_last_next     = held_last;
    long_seen_next     = long_seen;
    short_pending_next = short_pending;
    mode_reg_next      = mode_reg;
    duty_a_reg_next    = duty_a_reg;
    duty_b_reg_next    = duty_b_reg;
    press_event        = EV_NONE;
    if (key_down) begin
      held_last_next = 1'b1;
      if (!long_seen) begin
        if (hold_count_tick > long_threshold) begin
          long_seen_next     = 1'b1;
          short_pending_next = 1'b0;
          press_event        = EV_LONG;
          unique case (mode_reg)
            MODE_A: duty_a_reg_next = step_out;
            MODE_B: duty_b_reg_next = step_out;
            MODE_BOTH: begin
              duty_a_reg_next = step_out;
              duty_b_reg_next = step_out;
            end
            default: ;
          endcase
        end else begin
          short_pending_next = 1'b1;
        end
      end
    end else begin
      held_last_next  = 1'b0;
      long_seen_next  = 1'b0;
      hold_count_next = '0;
      if (short_pending) begin
        short_pending_next = 1'b0;
        press_event        = EV_SHORT;
        mode_reg_next      = mode_inc;
        unique case (mode_inc)
          MODE_OFF: begin
            duty_a_reg_next = '0;
            duty_b_reg_next = '0;
          end
          MODE_A: duty_a_reg_next = seed_a;
          MODE_B: duty_b_reg_next = seed_b;
          MODE_BOTH: begin
            duty_a_reg_next = seed_max;
            duty_b_reg_next = seed_max;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count <= '0;
      hold_count     <= '0;
      held_last      <= 1'b0;
      long_seen      <= 1'b0;
      short_pending  <= 1'b0;
      mode_reg       <= MODE_OFF;
      duty_a_reg     <= '0;
      duty_b_reg     <= '0;
    end else if (in_accept) begin
      prescale_count <= prescale_count_next;
      hold_count     <= hold_count_next;
      held_last      <= held_last_next;
      long_seen      <= long_seen_next;
      short_pending  <= short_pending_next;
      mode_reg       <= mode_reg_next;
      duty_a_reg     <= duty_a_reg_next;
      duty_b_reg     <= duty_b_reg_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_duty_a <= duty_a_reg_next;
      out_duty_b <= duty_b_reg_next;
      out_mode   <= mode_reg_next;
      out_event  <= press_event;
    end
  end

  assign m_axis_tdata = {4'b0, out_event, out_mode, out_duty_b, out_duty_a};

endmodule

### rtl/kpd_checker.sv
// ----------------------------------------------------------------------------
// key press dimmer control checker
// port level checks of the dimmer controller, bound to the top level
// ----------------------------------------------------------------------------
`include "key_press_dimmer_control_unit_defines.svh"

module kpd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [7:0]                    s_axis_tdata,   // key_down
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  // duty_a, duty_b, light_mode, press_event
  input logic [kpd_pkg::OUT_W-1:0]     m_axis_tdata,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [kpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [kpd_pkg::DUTY_W-1:0]    cfg_data
);
  import kpd_pkg::*;

  logic [DUTY_W-1:0] duty_a;
  logic [DUTY_W-1:0] duty_b;
  logic [1:0]        light_mode;
  logic [1:0]        press_event;
  logic              key_item;
  logic              in_item;

  assign duty_a      = m_axis_tdata[15:0];
  assign duty_b      = m_axis_tdata[31:16];
  assign light_mode  = m_axis_tdata[33:32];
  assign press_event = m_axis_tdata[35:34];
  assign in_item     = s_axis_tvalid && s_axis_tready;
  assign key_item    = s_axis_tdata[0];

  `KPD_ASSERT(a_off_clears, clk, rst, m_axis_tvalid && press_event == EV_SHORT && light_mode == MODE_OFF |-> duty_a == '0 && duty_b == '0, "short press into off left a duty set")

  `KPD_ASSERT(a_both_equal, clk, rst, m_axis_tvalid && light_mode == MODE_BOTH && press_event != EV_NONE |-> duty_a == duty_b, "both channels differ after a press")

  `KPD_ASSERT(a_item_result, clk, rst, in_item && !key_item |=> m_axis_tvalid && press_event != EV_LONG, "released key fired a long press or gave no result")

  `KPD_ASSERT(a_stall_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled output item changed")

  `KPD_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_axis_tvalid, "output valid right after reset")

endmodule

bind key_press_dimmer_control_unit kpd_checker u_kpd_checker (.*);

### tb/tb_key_press_dimmer_control_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// key press dimmer control unit testbench
// ticks with the key level go in one per item, and each output item is
// checked against a cycle model of the press detector and the dimmer kept in
// this bench. a short directed sweep covers the register extremes, long and
// short presses in every mode, wide duty sums and a lowered prescale limit.
// random press and release sequences under several register settings
// follow, with random idling on both streams and one long output stall.
// ----------------------------------------------------------------------------
module tb_key_press_dimmer_control_unit;
  import kpd_pkg::*;

  typedef struct {
    logic [DUTY_W-1:0] duty_a;
    logic [DUTY_W-1:0] duty_b;
    light_mode_t       mode;
    press_event_t      ev;
  } dimmer_out_t;

  typedef struct {
    bit                is_cfg;
    cfg_reg_t          idx;
    logic [DUTY_W-1:0] data;
    bit                key;
    bit                known;
    dimmer_out_t       res;
  } stim_row_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [OUT_W-1:0]     m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DUTY_W-1:0]    cfg_data  = '0;

  // model registers and state
  logic [DUTY_W-1:0]  step_r   = DUTY_STEP_RST;
  logic [DUTY_W-1:0]  total_r  = DUTY_TOTAL_RST;
  logic [COUNT_W-1:0] lim_r    = PRESCALE_LIMIT_RST;
  logic [COUNT_W-1:0] thr_r    = LONG_THRESHOLD_RST;
  logic [COUNT_W-1:0] pre_cnt  = '0;
  logic [COUNT_W-1:0] hold_cnt = '0;
  bit                 held       = 1'b0;
  bit                 long_seen  = 1'b0;
  bit                 short_pend = 1'b0;
  light_mode_t        mode_q     = MODE_OFF;
  logic [DUTY_W-1:0]  lvl_a      = '0;
  logic [DUTY_W-1:0]  lvl_b      = '0;

  dimmer_out_t pending_outputs[$];
  int          fail_cnt      = 0;
  int          snd_idle_pct  = 23;
  int          rcv_idle_pct  = 69;
  int          rcv_hold_left = 0;

  key_press_dimmer_control_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void note_fail(input string msg);
    if (fail_cnt < 10) begin
      $display("%s", msg);
    end
    fail_cnt++;
  endfunction

  // duty plus step at full width, wrapping to step above the total
  function automatic logic [DUTY_W-1:0] bump_duty(input logic [DUTY_W-1:0] d);
    logic [DUTY_W:0] s;
    s = {1'b0, d} + {1'b0, step_r};
    return (s > {1'b0, total_r}) ? step_r : s[DUTY_W-1:0];
  endfunction

  function automatic dimmer_out_t next_dimmer_output(input bit key);
    dimmer_out_t r;
    logic [1:0]  nxt;
    r.ev = EV_NONE;
    if (pre_cnt >= lim_r) begin
      pre_cnt = '0;
      if (held && !long_seen && hold_cnt < HOLD_MAX) begin
        hold_cnt = hold_cnt + 8'd1;
      end
    end
    if (key) begin
      held = 1'b1;
      if (!long_seen) begin
        if (hold_cnt > thr_r) begin
          long_seen  = 1'b1;
          short_pend = 1'b0;
          r.ev       = EV_LONG;
          case (mode_q)
            MODE_A: lvl_a = bump_duty(lvl_a);
            MODE_B: lvl_b = bump_duty(lvl_b);
            MODE_BOTH: begin
              lvl_a = bump_duty(lvl_a);
              lvl_b = lvl_a;
            end
            default: ;
          endcase
        end else begin
          short_pend = 1'b1;
        end
      end
    end else begin
      held      = 1'b0;
      long_seen = 1'b0;
      hold_cnt  = '0;
      if (short_pend) begin
        short_pend = 1'b0;
        r.ev       = EV_SHORT;
        nxt        = mode_q + 2'd1;
        mode_q     = light_mode_t'(nxt);
        case (mode_q)
          MODE_OFF: begin
            lvl_a = '0;
            lvl_b = '0;
          end
          MODE_A: if (lvl_a == '0) lvl_a = step_r;
          MODE_B: if (lvl_b == '0) lvl_b = step_r;
          default: begin
            if (lvl_a == '0) lvl_a = step_r;
            if (lvl_b == '0) lvl_b = step_r;
            if (lvl_a < lvl_b) lvl_a = lvl_b;
            else lvl_b = lvl_a;
          end
        endcase
      end
    end
    pre_cnt  = pre_cnt + 8'd1;
    r.duty_a = lvl_a;
    r.duty_b = lvl_b;
    r.mode   = mode_q;
    return r;
  endfunction

  function automatic stim_row_t tick_row(input bit key);
    stim_row_t row;
    row     = '{1'b0, REG_DUTY_STEP, '0, key, 1'b0, '{'0, '0, MODE_OFF, EV_NONE}};
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input cfg_reg_t idx, input logic [DUTY_W-1:0] data);
    stim_row_t row;
    row = '{1'b1, idx, data, 1'b0, 1'b0, '{'0, '0, MODE_OFF, EV_NONE}};
    return row;
  endfunction

  function automatic stim_row_t known_row(input bit key, input logic [DUTY_W-1:0] a,
                                          input logic [DUTY_W-1:0] b, input light_mode_t m,
                                          input press_event_t e);
    stim_row_t row;
    row = '{1'b0, REG_DUTY_STEP, '0, key, 1'b1, '{a, b, m, e}};
    return row;
  endfunction

  // called and returns at a falling edge
  task automatic send_tick(input bit key, input bit known, input dimmer_out_t known_res);
    dimmer_out_t r;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, key};
    do @(posedge clk); while (!s_tready);
    r = next_dimmer_output(key);
    pending_outputs.push_back(known ? known_res : r);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_outputs.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [DUTY_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DUTY_STEP:      step_r  = data;
      REG_DUTY_TOTAL:     total_r = data;
      REG_PRESCALE_LIMIT: lim_r   = data[COUNT_W-1:0];
      REG_LONG_THRESHOLD: thr_r   = data[COUNT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rcv_hold_left > 0) begin
      rcv_hold_left = rcv_hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    dimmer_out_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_outputs.size() == 0) begin
        note_fail($sformatf("unexpected output item %h", m_tdata));
      end else begin
        e = pending_outputs.pop_front();
        if (m_tdata[15:0] !== e.duty_a || m_tdata[31:16] !== e.duty_b ||
            m_tdata[33:32] !== e.mode || m_tdata[35:34] !== e.ev) begin
          note_fail($sformatf({"mismatch: expected a=%0d b=%0d mode=%0d ev=%0d, ",
                               "got a=%0d b=%0d mode=%0d ev=%0d"},
                              e.duty_a, e.duty_b, e.mode, e.ev, m_tdata[15:0],
                              m_tdata[31:16], m_tdata[33:32], m_tdata[35:34]));
        end
      end
    end
  end

  initial begin
    stim_row_t         rows[$];
    dimmer_out_t       blank;
    int                ph;
    int                cnt;
    int                needed;
    int                h;
    int                i;
    logic [DUTY_W-1:0] st;
    logic [DUTY_W-1:0] tot;
    logic [DUTY_W-1:0] lim;
    logic [DUTY_W-1:0] thr;

    blank = '{'0, '0, MODE_OFF, EV_NONE};

    rows.push_back(known_row(1'b0, 16'd0, 16'd0, MODE_OFF, EV_NONE));
    rows.push_back(tick_row(1'b1));
    rows.push_back(known_row(1'b0, 16'd10, 16'd0, MODE_A, EV_SHORT));
    // fast presses: with a zero prescale limit the prescaler wraps on every tick
    rows.push_back(cfg_row(REG_PRESCALE_LIMIT, 16'd0));
    rows.push_back(cfg_row(REG_LONG_THRESHOLD, 16'd0));
    rows.push_back(tick_row(1'b1));
    rows.push_back(tick_row(1'b1));
    rows.push_back(tick_row(1'b1));
    rows.push_back(tick_row(1'b0));
    // wide sums wrap to step
    rows.push_back(cfg_row(REG_DUTY_STEP, 16'hFFFF));
    rows.push_back(cfg_row(REG_DUTY_TOTAL, 16'hFFFF));
    rows.push_back(tick_row(1'b1));
    rows.push_back(known_row(1'b1, 16'hFFFF, 16'd0, MODE_A, EV_LONG));
    rows.push_back(tick_row(1'b0));
    rows.push_back(tick_row(1'b1));
    rows.push_back(tick_row(1'b1));
    rows.push_back(tick_row(1'b0));
    // zero step and zero total, through every mode
    rows.push_back(cfg_row(REG_DUTY_STEP, 16'd0));
    rows.push_back(cfg_row(REG_DUTY_TOTAL, 16'd0));
    rows.push_back(tick_row(1'b1));
    rows.push_back(tick_row(1'b0));
    rows.push_back(tick_row(1'b1));
    rows.push_back(tick_row(1'b1));
    rows.push_back(tick_row(1'b0));
    rows.push_back(tick_row(1'b1));
    rows.push_back(tick_row(1'b0));
    rows.push_back(tick_row(1'b1));
    rows.push_back(known_row(1'b0, 16'd0, 16'd0, MODE_OFF, EV_SHORT));
    // prescaler above a lowered limit
    rows.push_back(cfg_row(REG_PRESCALE_LIMIT, 16'd200));
    rows.push_back(tick_row(1'b0));
    rows.push_back(cfg_row(REG_PRESCALE_LIMIT, 16'd1));
    rows.push_back(tick_row(1'b1));
    rows.push_back(tick_row(1'b1));
    rows.push_back(tick_row(1'b0));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        wait_idle();
        write_reg(rows[i].idx, rows[i].data);
      end else begin
        send_tick(rows[i].key, rows[i].known, rows[i].res);
      end
    end

    for (ph = 0; ph < 9; ph++) begin
      wait_idle();
      snd_idle_pct = (ph < 3) ? 23 : (ph < 6) ? 69 : 0;
      rcv_idle_pct = (ph < 3) ? 69 : (ph < 6) ? 23 : 0;
      case (ph)
        0: begin st = 16'd10;    tot = 16'd100;   lim = 16'd5;   thr = 16'd20;  end
        1: begin st = 16'd1;     tot = 16'd3;     lim = 16'd0;   thr = 16'd0;   end
        2: begin st = 16'hFFFF;  tot = 16'hFFFF;  lim = 16'd0;   thr = 16'd1;   end
        3: begin st = 16'd0;     tot = 16'd0;     lim = 16'd1;   thr = 16'd2;   end
        4: begin st = 16'd7;     tot = 16'd50;    lim = 16'd0;   thr = 16'd255; end
        6: begin st = 16'd30000; tot = 16'hFFFF;  lim = 16'd255; thr = 16'd0;   end
        8: begin st = 16'd1;     tot = 16'hFFFF;  lim = 16'd0;   thr = 16'd249; end
        default: begin
          st  = DUTY_W'($urandom_range(0, 65535));
          tot = DUTY_W'($urandom_range(0, 65535));
          lim = DUTY_W'(($urandom_range(0, 255) << 8) | $urandom_range(0, 3));
          thr = DUTY_W'(($urandom_range(0, 255) << 8) | $urandom_range(0, 6));
        end
      endcase
      write_reg(REG_DUTY_STEP, st);
      write_reg(REG_DUTY_TOTAL, tot);
      write_reg(REG_PRESCALE_LIMIT, lim);
      write_reg(REG_LONG_THRESHOLD, thr);
      if (ph == 6) begin
        // long output stall while ticks keep coming
        @(posedge clk);
        rcv_hold_left = 80;
        @(negedge clk);
      end
      needed = (int'(thr_r) + 1) * (int'(lim_r) + 1) + 2;
      if (needed > 300) needed = 300;
      cnt = 0;
      while (cnt < 160) begin
        if ($urandom_range(0, 9) == 0) begin
          h = $urandom_range(1, 6);
          repeat (h) begin
            send_tick(1'($urandom_range(0, 1)), 1'b0, blank);
            cnt++;
          end
        end else begin
          if ($urandom_range(0, 2) == 0) h = needed + $urandom_range(0, 8);
          else h = $urandom_range(1, needed);
          repeat (h) begin
            send_tick(1'b1, 1'b0, blank);
            cnt++;
          end
          h = $urandom_range(1, 4);
          repeat (h) begin
            send_tick(1'b0, 1'b0, blank);
            cnt++;
          end
        end
      end
    end

    s_tvalid <= 1'b0;
    for (i = 0; i < 1000 && pending_outputs.size() != 0; i++) @(negedge clk);
    repeat (4) @(negedge clk);
    if (pending_outputs.size() != 0) begin
      note_fail($sformatf("%0d output items never arrived", pending_outputs.size()));
    end
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
